// ===== rtl/core/frws_pkg.sv =====
// shared widths and constants for the frame rate window statistics block
// no dependencies; imported by the interfaces and every module of the block
package frws_pkg;

    localparam int WINDOW_DEF = 60;

    localparam int TS_W     = 32;
    localparam int COUNT_W  = 6;
    localparam int RATE_W   = 18;
    localparam int MEAN_W   = 24;
    localparam int PCT_W    = 15;

    localparam int RATE_ONE = 256000;   // 1000.0 with 8 fraction bits
    localparam int PCT_ONE  = 25600;    // 100.0 with 8 fraction bits

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_STATS_ENABLE = 1'b0;

endpackage

// ===== rtl/core/frws_in_if.sv =====
// frame event channel: valid/ready handshake with timestamp and dropped flag
// depends on frws_pkg
interface frws_in_if import frws_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [TS_W-1:0]     timestamp_ms;
    logic                drop_flag;

    modport source (output valid, output timestamp_ms, output drop_flag, input ready);
    modport sink   (input valid, input timestamp_ms, input drop_flag, output ready);

endinterface

// ===== rtl/core/frws_out_if.sv =====
// statistics result channel: valid/ready handshake with the rate fields
// depends on frws_pkg
interface frws_out_if import frws_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                stats_valid;
    logic [COUNT_W-1:0]  sample_count;
    logic [RATE_W-1:0]   fps_now;
    logic [MEAN_W-1:0]   fps_mean;
    logic [RATE_W-1:0]   fps_peak;
    logic [RATE_W-1:0]   fps_low;
    logic [PCT_W-1:0]    dropped_percent;

    modport source (
        output valid, output stats_valid, output sample_count, output fps_now,
        output fps_mean, output fps_peak, output fps_low, output dropped_percent,
        input ready
    );
    modport sink (
        input valid, input stats_valid, input sample_count, input fps_now,
        input fps_mean, input fps_peak, input fps_low, input dropped_percent,
        output ready
    );

endinterface

// ===== rtl/core/frws_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit divisor
// depends on frws_pkg; used by frame_rate_window_statistics
module frws_div import frws_pkg::*; #(
    parameter int NUM_W = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [TS_W-1:0]   divisor,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [TS_W-1:0]   rem_reg,   rem_next;
    logic [NUM_W-1:0]  quo_reg,   quo_next;
    logic [TS_W-1:0]   dsr_reg,   dsr_next;

    logic [TS_W:0]     shifted;
    logic              ge;
    logic [TS_W:0]     diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (shifted >= {1'b0, dsr_reg});
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out of the top while quotient bits enter below
            rem_next = ge ? diff[TS_W-1:0] : shifted[TS_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/frame_rate_window_statistics.sv =====
// frame rate window statistics over a circular sample memory
// depends on frws_pkg, frws_in_if, frws_out_if and frws_div
//
// usage:
//   frame_in carries one frame event per transfer (timestamp_ms, drop_flag).
//   stats_out carries exactly one result per accepted event: rates over the
//   samples stored before that event, then the event is pushed as newest.
//   stats_enable is written through the APB port at address 0; while it is 0
//   each event empties the window, is not stored and gets an all-zero result.
// event flow:
//   an event is taken only when the block is idle, so the next event waits
//   until the current result has been loaded into the output register. the
//   block walks the stored samples with one memory read per sample, then runs
//   five divisions in one shared restoring divider at one quotient bit per
//   cycle. an empty or disabled window skips the walk and the divisions.
// reset:
//   the window is empty and stats_enable is 0; no memory clearing is needed.
// stalls:
//   the result sits in an output register; the next event may be taken while
//   it waits, and that event's result holds until stats_out.ready is high.
module frame_rate_window_statistics import frws_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    frws_in_if.sink                 frame_in,
    frws_out_if.source              stats_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int NUM_W = $clog2(WINDOW * RATE_ONE + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [2:0] DV_NOW  = 3'd0;
    localparam logic [2:0] DV_MEAN = 3'd1;
    localparam logic [2:0] DV_PEAK = 3'd2;
    localparam logic [2:0] DV_LOW  = 3'd3;
    localparam logic [2:0] DV_PCT  = 3'd4;

    // configuration
    logic stats_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stats_enable_reg <= 1'b0;
        else if (psel && penable && pwrite && (paddr[2] == REG_STATS_ENABLE))
            stats_enable_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STATS_ENABLE) ?
                    {{(APB_DATA_W-1){1'b0}}, stats_enable_reg} : '0;

    // sample memory, newest entry at head_reg
    logic [TS_W:0]      mem [WINDOW];
    logic [TS_W:0]      rdata_reg;
    logic [PTR_W-1:0]   rd_addr;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;

    // control
    logic [1:0]         state_reg,    state_next;
    logic [PTR_W-1:0]   head_reg,     head_next;
    logic [PTR_W-1:0]   rd_ptr_reg,   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CNT_W-1:0]   age_reg,      age_next;
    logic               stats_reg,    stats_next;
    logic               push_reg,     push_next;
    logic [2:0]         sel_reg,      sel_next;
    logic               started_reg,  started_next;
    logic               ovalid_reg,   ovalid_next;

    // working values
    logic [TS_W-1:0]    t_reg,        t_next;
    logic               drop_reg,     drop_next;
    logic [TS_W-1:0]    prev_reg,     prev_next;
    logic [TS_W-1:0]    now_reg,      now_next;
    logic [TS_W-1:0]    min_reg,      min_next;
    logic [TS_W-1:0]    max_reg,      max_next;
    logic [TS_W-1:0]    span_reg,     span_next;
    logic [CNT_W-1:0]   drops_reg,    drops_next;
    logic [RATE_W-1:0]  q_now_reg,    q_now_next;
    logic [MEAN_W-1:0]  q_mean_reg,   q_mean_next;
    logic [RATE_W-1:0]  q_peak_reg,   q_peak_next;
    logic [RATE_W-1:0]  q_low_reg,    q_low_next;
    logic [PCT_W-1:0]   q_pct_reg,    q_pct_next;

    // output register
    logic               o_stats_reg,  o_stats_next;
    logic [COUNT_W-1:0] o_count_reg,  o_count_next;
    logic [RATE_W-1:0]  o_now_reg,    o_now_next;
    logic [MEAN_W-1:0]  o_mean_reg,   o_mean_next;
    logic [RATE_W-1:0]  o_peak_reg,   o_peak_next;
    logic [RATE_W-1:0]  o_low_reg,    o_low_next;
    logic [PCT_W-1:0]   o_pct_reg,    o_pct_next;

    // divider
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [TS_W-1:0]    div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;

    logic               in_fire;
    logic [TS_W-1:0]    rd_ts;
    logic               rd_drop;
    logic [TS_W-1:0]    gap;
    logic [PTR_W-1:0]   head_dec;
    logic [PTR_W-1:0]   rd_ptr_dec;

    function automatic logic [TS_W-1:0] clamp_iv(input logic [TS_W-1:0] v);
        clamp_iv = (v == '0) ? TS_W'(1) : v;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_W'(WINDOW - 1) : p - 1'b1;
    endfunction

    assign frame_in.ready = (state_reg == S_IDLE);
    assign in_fire        = frame_in.valid && (state_reg == S_IDLE);
    assign rd_ts          = rdata_reg[TS_W:1];
    assign rd_drop        = rdata_reg[0];
    assign gap            = prev_reg - rd_ts;
    assign head_dec       = ptr_dec(head_reg);
    assign rd_ptr_dec     = ptr_dec(rd_ptr_reg);
    assign rd_addr        = (state_reg == S_IDLE) ? head_reg : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {t_reg, drop_reg};
        rdata_reg <= mem[rd_addr];
    end

    // divider operands
    always_comb
    begin
        unique case (sel_reg)
            DV_NOW:
            begin
                div_num = NUM_W'(RATE_ONE);
                div_den = clamp_iv(now_reg);
            end
            DV_MEAN:
            begin
                div_num = NUM_W'(count_reg) * NUM_W'(RATE_ONE);
                div_den = clamp_iv(span_reg);
            end
            DV_PEAK:
            begin
                div_num = NUM_W'(RATE_ONE);
                div_den = clamp_iv(min_reg);
            end
            DV_LOW:
            begin
                div_num = NUM_W'(RATE_ONE);
                div_den = clamp_iv(max_reg);
            end
            default:
            begin
                div_num = NUM_W'(drops_reg) * NUM_W'(PCT_ONE);
                div_den = TS_W'(count_reg);
            end
        endcase
    end

    assign div_start = (state_reg == S_DIV) && !started_reg;

    frws_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        age_next     = age_reg;
        stats_next   = stats_reg;
        push_next    = push_reg;
        sel_next     = sel_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg;
        t_next       = t_reg;
        drop_next    = drop_reg;
        prev_next    = prev_reg;
        now_next     = now_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        span_next    = span_reg;
        drops_next   = drops_reg;
        q_now_next   = q_now_reg;
        q_mean_next  = q_mean_reg;
        q_peak_next  = q_peak_reg;
        q_low_next   = q_low_reg;
        q_pct_next   = q_pct_reg;
        o_stats_next = o_stats_reg;
        o_count_next = o_count_reg;
        o_now_next   = o_now_reg;
        o_mean_next  = o_mean_reg;
        o_peak_next  = o_peak_reg;
        o_low_next   = o_low_reg;
        o_pct_next   = o_pct_reg;
        wr_en        = 1'b0;
        wr_addr      = (head_reg == PTR_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;

        if (ovalid_reg && stats_out.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    t_next      = frame_in.timestamp_ms;
                    drop_next   = frame_in.drop_flag;
                    rd_ptr_next = head_dec;
                    age_next    = '0;
                    sel_next    = DV_NOW;
                    started_next = 1'b0;
                    if (!stats_enable_reg)
                    begin
                        count_next = '0;
                        stats_next = 1'b0;
                        push_next  = 1'b0;
                        state_next = S_OUT;
                    end
                    else if (count_reg == '0)
                    begin
                        stats_next = 1'b0;
                        push_next  = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        stats_next = 1'b1;
                        push_next  = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // rdata_reg holds the sample of age age_reg, newest first
                rd_ptr_next = rd_ptr_dec;
                prev_next   = rd_ts;
                age_next    = age_reg + 1'b1;
                if (age_reg == '0)
                begin
                    now_next   = t_reg - rd_ts;
                    min_next   = t_reg - rd_ts;
                    max_next   = t_reg - rd_ts;
                    drops_next = CNT_W'(rd_drop);
                end
                else
                begin
                    if (gap < min_reg)
                        min_next = gap;
                    if (gap > max_reg)
                        max_next = gap;
                    drops_next = drops_reg + CNT_W'(rd_drop);
                end
                if (age_reg == count_reg - 1'b1)
                begin
                    span_next  = t_reg - rd_ts;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!started_reg)
                    started_next = 1'b1;
                else if (div_done)
                begin
                    started_next = 1'b0;
                    sel_next     = sel_reg + 1'b1;
                    unique case (sel_reg)
                        DV_NOW:  q_now_next  = RATE_W'(div_quo);
                        DV_MEAN: q_mean_next = MEAN_W'(div_quo);
                        DV_PEAK: q_peak_next = RATE_W'(div_quo);
                        DV_LOW:  q_low_next  = RATE_W'(div_quo);
                        default: q_pct_next  = PCT_W'(div_quo);
                    endcase
                    if (sel_reg == DV_PCT)
                        state_next = S_OUT;
                end
            end
            default:
            begin
                // wait for the output register to free up, then load the result and push the sample if push_reg is set
                if (!ovalid_reg || stats_out.ready)
                begin
                    ovalid_next  = 1'b1;
                    o_stats_next = stats_reg;
                    o_count_next = stats_reg ? COUNT_W'(count_reg) : '0;
                    o_now_next   = stats_reg ? q_now_reg  : '0;
                    o_mean_next  = stats_reg ? q_mean_reg : '0;
                    o_peak_next  = stats_reg ? q_peak_reg : '0;
                    o_low_next   = stats_reg ? q_low_reg  : '0;
                    o_pct_next   = stats_reg ? q_pct_reg  : '0;
                    if (push_reg)
                    begin
                        wr_en     = 1'b1;
                        head_next = wr_addr;
                        if (count_reg != CNT_W'(WINDOW))
                            count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            age_reg     <= '0;
            stats_reg   <= 1'b0;
            push_reg    <= 1'b0;
            sel_reg     <= DV_NOW;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            age_reg     <= age_next;
            stats_reg   <= stats_next;
            push_reg    <= push_next;
            sel_reg     <= sel_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        drop_reg    <= drop_next;
        prev_reg    <= prev_next;
        now_reg     <= now_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        span_reg    <= span_next;
        drops_reg   <= drops_next;
        q_now_reg   <= q_now_next;
        q_mean_reg  <= q_mean_next;
        q_peak_reg  <= q_peak_next;
        q_low_reg   <= q_low_next;
        q_pct_reg   <= q_pct_next;
        o_stats_reg <= o_stats_next;
        o_count_reg <= o_count_next;
        o_now_reg   <= o_now_next;
        o_mean_reg  <= o_mean_next;
        o_peak_reg  <= o_peak_next;
        o_low_reg   <= o_low_next;
        o_pct_reg   <= o_pct_next;
    end

    assign stats_out.valid           = ovalid_reg;
    assign stats_out.stats_valid     = o_stats_reg;
    assign stats_out.sample_count    = o_count_reg;
    assign stats_out.fps_now         = o_now_reg;
    assign stats_out.fps_mean        = o_mean_reg;
    assign stats_out.fps_peak        = o_peak_reg;
    assign stats_out.fps_low         = o_low_reg;
    assign stats_out.dropped_percent = o_pct_reg;

endmodule
